// ===== src/rgba_box_blur_3x3_defines.svh =====
// Assertion macros shared by the blur datapath modules.
`ifndef RGBA_BOX_BLUR_3X3_DEFINES_SVH
`define RGBA_BOX_BLUR_3X3_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define BBLUR_ASSERT_IMP(name, clk, rst, pre, post) \
  name: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
    else $error("%m: implication failed");

// Next-cycle implication, checked outside reset.
`define BBLUR_ASSERT_NXT(name, clk, rst, pre, post) \
  name: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
    else $error("%m: next-cycle implication failed");

`endif

// ===== src/bblur_pkg.sv =====
`default_nettype none

package bblur_pkg;

  // Frame limits and field widths
  localparam int MAX_WIDTH  = 4096;
  localparam int MAX_HEIGHT = 4096;
  localparam int SIZE_W     = 13;
  localparam int COL_W      = $clog2(MAX_WIDTH);
  localparam int ROW_W      = $clog2(MAX_HEIGHT);
  localparam int CFG_IDX_W  = 2;

  localparam logic [SIZE_W-1:0] MIN_SIZE     = SIZE_W'(2);
  localparam logic [SIZE_W-1:0] MAX_WIDTH_SZ  = SIZE_W'(MAX_WIDTH);
  localparam logic [SIZE_W-1:0] MAX_HEIGHT_SZ = SIZE_W'(MAX_HEIGHT);

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = CFG_IDX_W'(1);
  localparam logic [SIZE_W-1:0]    WIDTH_RESET      = SIZE_W'(640);
  localparam logic [SIZE_W-1:0]    HEIGHT_RESET     = SIZE_W'(480);

  // Pixel layout: channel 0 red, 1 green, 2 blue, 3 alpha
  localparam int CH_W       = 8;
  localparam int NUM_CH     = 4;
  localparam int NUM_SUM_CH = 3;
  localparam int CH_ALPHA   = 3;
  localparam int PIX_W      = CH_W * NUM_CH;

  typedef logic [NUM_CH-1:0][CH_W-1:0] pix_t;

  // Column sum of up to three samples, window sum of up to nine
  localparam int COLS_W = CH_W + 2;
  localparam int SUM_W  = CH_W + 4;

  // Reciprocals for the truncated divide by 6 and by 9
  localparam int RECIP_W      = 14;
  localparam int RECIP6_SHIFT = 16;
  localparam int RECIP9_SHIFT = 15;
  localparam logic [RECIP_W-1:0] RECIP6 = RECIP_W'(((2 ** RECIP6_SHIFT) + 5) / 6);
  localparam logic [RECIP_W-1:0] RECIP9 = RECIP_W'(((2 ** RECIP9_SHIFT) + 8) / 9);

  typedef enum logic [1:0] {
    DIV_4 = 2'd0,
    DIV_6 = 2'd1,
    DIV_9 = 2'd2
  } div_t;

  // Results that one item can cause
  localparam int NUM_REC   = 4;
  localparam int REC_IDX_W = $clog2(NUM_REC);

  typedef struct packed {
    logic [NUM_SUM_CH-1:0][SUM_W-1:0] sum;
    div_t                             div;
    logic [CH_W-1:0]                  alpha;
    logic [ROW_W-1:0]                 row;
    logic [COL_W-1:0]                 col;
    logic                             last;
    logic                             done;
  } rec_t;

  typedef struct packed {
    logic [NUM_REC-1:0]      mask;
    rec_t [NUM_REC-1:0]      rec;
  } burst_t;

  // Frame geometry and restart from the register file
  typedef struct packed {
    logic             restart;
    logic [COL_W-1:0] col_last;
    logic [ROW_W-1:0] row_last;
  } frame_ctl_t;

endpackage

`default_nettype wire

// ===== src/bblur_if.sv =====
`default_nettype none

// Incoming pixel channel
interface bblur_pixel_if import bblur_pkg::*; ();
  logic            valid;
  logic            ready;
  logic [CH_W-1:0] red_in;
  logic [CH_W-1:0] green_in;
  logic [CH_W-1:0] blue_in;
  logic [CH_W-1:0] alpha_in;

  modport source (output valid, red_in, green_in, blue_in, alpha_in, input ready);
  modport sink   (input valid, red_in, green_in, blue_in, alpha_in, output ready);
endinterface

// Blurred result channel
interface bblur_result_if import bblur_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [CH_W-1:0]  red_out;
  logic [CH_W-1:0]  green_out;
  logic [CH_W-1:0]  blue_out;
  logic [CH_W-1:0]  alpha_out;
  logic [ROW_W-1:0] out_row;
  logic [COL_W-1:0] out_col;
  logic             last_of_run;
  logic             frame_done;

  modport source (output valid, red_out, green_out, blue_out, alpha_out, out_row, out_col,
                  last_of_run, frame_done, input ready);
  modport sink   (input valid, red_out, green_out, blue_out, alpha_out, out_row, out_col,
                  last_of_run, frame_done, output ready);
endinterface

// Register write channel
interface bblur_cfg_if import bblur_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [SIZE_W-1:0]    data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

// ===== src/rgba_box_blur_3x3.sv =====
// Path: line-buffer read stage, then the result slots, then the output register.
// Throughput: one item per cycle while the output accepts; an item that causes more than one
// result (two on the right column and the bottom row, four at bottom-right) holds the input
// until its last result is taken, one result out per cycle while the output accepts.
// Reset: synchronous; size returns to 640 x 480 and the next item is pixel (0,0).
// Line buffers need no clearing pass: entries read for rows above the frame are masked to zero.
`default_nettype none

module rgba_box_blur_3x3 import bblur_pkg::*; (
  input  logic           clk,
  input  logic           rst,
  bblur_pixel_if.sink    pixel,
  bblur_result_if.source result,
  bblur_cfg_if.sink      cfg
);

  logic [SIZE_W-1:0] image_width;
  logic [SIZE_W-1:0] image_height;
  logic [SIZE_W-1:0] width_eff;
  logic [SIZE_W-1:0] height_eff;
  logic              cfg_write;
  frame_ctl_t        frame;
  logic              burst_valid;
  logic              burst_ready;
  burst_t            burst;

  function automatic logic [SIZE_W-1:0] clamp_size(input logic [SIZE_W-1:0] v,
                                                   input logic [SIZE_W-1:0] hi);
    logic [SIZE_W-1:0] r;
    if (v < MIN_SIZE) begin
      r = MIN_SIZE;
    end else if (v > hi) begin
      r = hi;
    end else begin
      r = v;
    end
    return r;
  endfunction

  assign cfg.ready = 1'b1;
  assign cfg_write = cfg.valid && cfg.ready;

  // Register file
  always_ff @(posedge clk) begin
    if (rst) begin
      image_width  <= WIDTH_RESET;
      image_height <= HEIGHT_RESET;
    end else if (cfg_write) begin
      case (cfg.index)
        REG_IMAGE_WIDTH:  image_width  <= cfg.data;
        REG_IMAGE_HEIGHT: image_height <= cfg.data;
        default: ;
      endcase
    end
  end

  // Frame geometry; any listed register write restarts the frame
  assign width_eff      = clamp_size(image_width, MAX_WIDTH_SZ);
  assign height_eff     = clamp_size(image_height, MAX_HEIGHT_SZ);
  assign frame.col_last = COL_W'(width_eff - SIZE_W'(1));
  assign frame.row_last = ROW_W'(height_eff - SIZE_W'(1));
  assign frame.restart  = cfg_write &&
                          (cfg.index == REG_IMAGE_WIDTH || cfg.index == REG_IMAGE_HEIGHT);

  bblur_window u_window (
    .clk         (clk),
    .rst         (rst),
    .frame       (frame),
    .pixel       (pixel),
    .burst_valid (burst_valid),
    .burst_ready (burst_ready),
    .burst       (burst)
  );

  bblur_emit u_emit (
    .clk         (clk),
    .rst         (rst),
    .burst_valid (burst_valid),
    .burst_ready (burst_ready),
    .burst       (burst),
    .result      (result)
  );

endmodule

`default_nettype wire

// ===== src/bblur_ram.sv =====
`default_nettype none

module bblur_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read, held while not enabled
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// ===== src/bblur_window.sv =====
`default_nettype none

`include "rgba_box_blur_3x3_defines.svh"

module bblur_window import bblur_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  frame_ctl_t  frame,
  bblur_pixel_if.sink pixel,
  output logic        burst_valid,
  input  logic        burst_ready,
  output burst_t      burst
);

  // Position of the next item
  logic [ROW_W-1:0] row;
  logic [COL_W-1:0] col;
  logic [ROW_W-1:0] r_eff;
  logic [COL_W-1:0] c_eff;

  // Line-buffer read stage
  logic             s1_valid;
  pix_t             s1_px;
  logic [ROW_W-1:0] s1_row;
  logic [COL_W-1:0] s1_col;
  logic             s1_go;
  logic             accept;

  // Line-buffer ports
  logic             ram_re;
  logic             ram_we;
  logic [COL_W-1:0] ram_raddr;
  logic [COL_W-1:0] ram_waddr;
  pix_t             older_q;
  pix_t             recent_q;

  // Window: columns c-2 and c-1, rows top, middle, bottom
  pix_t [2:0]      win_a;
  pix_t [2:0]      win_b;
  pix_t [2:0]      cur;
  pix_t [2:0][2:0] win;

  logic skip_top;
  logic skip_left;
  logic [2:0][NUM_SUM_CH-1:0][COLS_W-1:0] low;
  logic [2:0][NUM_SUM_CH-1:0][COLS_W-1:0] full;
  logic [NUM_REC-1:0] mask;

  function automatic div_t div_of(input logic three_cols, input logic three_rows);
    div_t d;
    if (three_cols && three_rows) begin
      d = DIV_9;
    end else if (three_cols || three_rows) begin
      d = DIV_6;
    end else begin
      d = DIV_4;
    end
    return d;
  endfunction

  assign accept      = pixel.valid && pixel.ready;
  assign s1_go       = s1_valid && burst_ready;
  assign pixel.ready = !s1_valid || burst_ready;

  // Fall back to the frame origin if the position lies outside the frame
  always_comb begin
    if (row > frame.row_last || col > frame.col_last) begin
      r_eff = '0;
      c_eff = '0;
    end else begin
      r_eff = row;
      c_eff = col;
    end
  end

  // Advance the raster position
  always_ff @(posedge clk) begin
    if (rst || frame.restart) begin
      row <= '0;
      col <= '0;
    end else if (accept) begin
      if (c_eff == frame.col_last) begin
        col <= '0;
        row <= (r_eff == frame.row_last) ? '0 : r_eff + ROW_W'(1);
      end else begin
        col <= c_eff + COL_W'(1);
        row <= r_eff;
      end
    end
  end

  // Hold the item while the line buffers answer
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (pixel.ready) begin
      s1_valid <= pixel.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_px  <= {pixel.alpha_in, pixel.blue_in, pixel.green_in, pixel.red_in};
      s1_row <= r_eff;
      s1_col <= c_eff;
    end
  end

  // Read at accept, write back as the item leaves; an entry is read again
  // only a full row later, so the two never meet on one address
  assign ram_re    = accept;
  assign ram_raddr = c_eff;
  assign ram_we    = s1_go;
  assign ram_waddr = s1_col;

  bblur_ram #(.WIDTH(PIX_W), .DEPTH(MAX_WIDTH)) u_older (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (cur[1]),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (older_q)
  );

  bblur_ram #(.WIDTH(PIX_W), .DEPTH(MAX_WIDTH)) u_recent (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (s1_px),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (recent_q)
  );

  // Current column, rows above the frame read as zero
  assign cur[0] = (s1_row >= ROW_W'(2)) ? older_q : '0;
  assign cur[1] = (s1_row != '0) ? recent_q : '0;
  assign cur[2] = s1_px;

  assign win[0] = win_a;
  assign win[1] = win_b;
  assign win[2] = cur;

  assign skip_top  = (s1_row == ROW_W'(1));
  assign skip_left = (s1_col == COL_W'(1));

  // Shift the window as the item leaves
  always_ff @(posedge clk) begin
    if (rst) begin
      win_a <= '0;
      win_b <= '0;
    end else if (s1_go) begin
      win_a <= win_b;
      win_b <= cur;
    end
  end

  // Column sums: middle and bottom, and with the top row where it counts
  always_comb begin
    for (int j = 0; j < 3; j++) begin
      for (int k = 0; k < NUM_SUM_CH; k++) begin
        low[j][k]  = COLS_W'(win[j][1][k]) + COLS_W'(win[j][2][k]);
        full[j][k] = low[j][k] + (skip_top ? '0 : COLS_W'(win[j][0][k]));
      end
    end
  end

  // Results due for this item, in raster order
  assign mask[0] = (s1_row != '0) && (s1_col != '0);
  assign mask[1] = (s1_row != '0) && (s1_col == frame.col_last);
  assign mask[2] = (s1_row == frame.row_last) && (s1_col != '0);
  assign mask[3] = (s1_row == frame.row_last) && (s1_col == frame.col_last);

  always_comb begin
    burst.mask = mask;

    // Centre one row up and one column left
    for (int k = 0; k < NUM_SUM_CH; k++) begin
      burst.rec[0].sum[k] = (skip_left ? '0 : SUM_W'(full[0][k]))
                          + SUM_W'(full[1][k]) + SUM_W'(full[2][k]);
    end
    burst.rec[0].div   = div_of(!skip_left, !skip_top);
    burst.rec[0].alpha = win[1][1][CH_ALPHA];
    burst.rec[0].row   = s1_row - ROW_W'(1);
    burst.rec[0].col   = s1_col - COL_W'(1);
    burst.rec[0].last  = mask[0] && !(|mask[3:1]);
    burst.rec[0].done  = 1'b0;

    // Right edge, one row up
    for (int k = 0; k < NUM_SUM_CH; k++) begin
      burst.rec[1].sum[k] = SUM_W'(full[1][k]) + SUM_W'(full[2][k]);
    end
    burst.rec[1].div   = div_of(1'b0, !skip_top);
    burst.rec[1].alpha = win[2][1][CH_ALPHA];
    burst.rec[1].row   = s1_row - ROW_W'(1);
    burst.rec[1].col   = s1_col;
    burst.rec[1].last  = mask[1] && !(|mask[3:2]);
    burst.rec[1].done  = 1'b0;

    // Bottom edge, one column left
    for (int k = 0; k < NUM_SUM_CH; k++) begin
      burst.rec[2].sum[k] = (skip_left ? '0 : SUM_W'(low[0][k]))
                          + SUM_W'(low[1][k]) + SUM_W'(low[2][k]);
    end
    burst.rec[2].div   = div_of(!skip_left, 1'b0);
    burst.rec[2].alpha = win[1][2][CH_ALPHA];
    burst.rec[2].row   = s1_row;
    burst.rec[2].col   = s1_col - COL_W'(1);
    burst.rec[2].last  = mask[2] && !mask[3];
    burst.rec[2].done  = 1'b0;

    // Bottom-right corner
    for (int k = 0; k < NUM_SUM_CH; k++) begin
      burst.rec[3].sum[k] = SUM_W'(low[1][k]) + SUM_W'(low[2][k]);
    end
    burst.rec[3].div   = DIV_4;
    burst.rec[3].alpha = win[2][2][CH_ALPHA];
    burst.rec[3].row   = s1_row;
    burst.rec[3].col   = s1_col;
    burst.rec[3].last  = mask[3];
    burst.rec[3].done  = 1'b1;
  end

  assign burst_valid = s1_valid;

  `BBLUR_ASSERT_IMP(a_no_addr_clash, clk, rst, ram_re && ram_we, ram_raddr != ram_waddr)
  `BBLUR_ASSERT_IMP(a_pos_in_frame, clk, rst, 1'b1,
                    row <= frame.row_last && col <= frame.col_last)
  `BBLUR_ASSERT_NXT(a_stall_holds, clk, rst, s1_valid && !burst_ready,
                    s1_valid && $stable(s1_col) && $stable(s1_row))

endmodule

`default_nettype wire

// ===== src/bblur_emit.sv =====
`default_nettype none

`include "rgba_box_blur_3x3_defines.svh"

module bblur_emit import bblur_pkg::*; (
  input  logic           clk,
  input  logic           rst,
  input  logic           burst_valid,
  output logic           burst_ready,
  input  burst_t         burst,
  bblur_result_if.source result
);

  // Pending results of one item
  rec_t [NUM_REC-1:0] slot;
  logic [NUM_REC-1:0] slot_mask;
  logic [NUM_REC-1:0] remain;
  logic [NUM_REC-1:0] sel_hot;
  logic [REC_IDX_W-1:0] sel;
  logic out_load;
  logic pop;

  // Truncated mean by shift or reciprocal multiply
  function automatic logic [CH_W-1:0] mean(input logic [SUM_W-1:0] s, input div_t d);
    logic [RECIP_W-1:0]       recip;
    logic [SUM_W+RECIP_W-1:0] p;
    logic [SUM_W-1:0]         q;
    recip = (d == DIV_9) ? RECIP9 : RECIP6;
    p     = s * recip;
    case (d)
      DIV_6:   q = SUM_W'(p >> RECIP6_SHIFT);
      DIV_9:   q = SUM_W'(p >> RECIP9_SHIFT);
      default: q = s >> 2;
    endcase
    return q[CH_W-1:0];
  endfunction

  // Pick the lowest pending result
  always_comb begin
    sel = '0;
    for (int i = NUM_REC - 1; i >= 0; i--) begin
      if (slot_mask[i]) begin
        sel = REC_IDX_W'(i);
      end
    end
  end

  assign sel_hot     = NUM_REC'(1) << sel;
  assign out_load    = !result.valid || result.ready;
  assign pop         = out_load && (slot_mask != '0);
  assign remain      = pop ? (slot_mask & ~sel_hot) : slot_mask;
  assign burst_ready = (remain == '0);

  // Refill the slots once the last pending result leaves
  always_ff @(posedge clk) begin
    if (rst) begin
      slot_mask <= '0;
    end else if (burst_valid && burst_ready) begin
      slot_mask <= burst.mask;
    end else begin
      slot_mask <= remain;
    end
  end

  always_ff @(posedge clk) begin
    if (burst_valid && burst_ready) begin
      slot <= burst.rec;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      result.valid <= 1'b0;
    end else if (out_load) begin
      result.valid <= (slot_mask != '0);
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      result.red_out     <= mean(slot[sel].sum[0], slot[sel].div);
      result.green_out   <= mean(slot[sel].sum[1], slot[sel].div);
      result.blue_out    <= mean(slot[sel].sum[2], slot[sel].div);
      result.alpha_out   <= slot[sel].alpha;
      result.out_row     <= slot[sel].row;
      result.out_col     <= slot[sel].col;
      result.last_of_run <= slot[sel].last;
      result.frame_done  <= slot[sel].done;
    end
  end

  `BBLUR_ASSERT_IMP(a_done_is_last, clk, rst, result.valid && result.frame_done,
                    result.last_of_run)
  `BBLUR_ASSERT_NXT(a_pop_shows, clk, rst, pop, result.valid)
  `BBLUR_ASSERT_IMP(a_last_empties, clk, rst, pop && slot[sel].last, remain == '0)

endmodule

`default_nettype wire
